// ===== src/mfsp_pkg.sv =====
`default_nettype none
package mfsp_pkg;

    localparam int unsigned PROGRAM_COUNT_DEF = 16;
    localparam int unsigned MAX_TEMPOS_DEF    = 1024;

    localparam logic [31:0] HDR_SIG   = 32'h4D546864;
    localparam logic [31:0] TRK_SIG   = 32'h4D54726B;
    localparam logic [20:0] MAX_EVENTS_RST = 21'd65536;
    localparam logic [19:0] COUNT_SAT = 20'hFFFFF;

    typedef enum logic [3:0] {
        EV_HEADER  = 4'd0,
        EV_VEL     = 4'd1,
        EV_PITCH   = 4'd2,
        EV_VOLUME  = 4'd3,
        EV_PAN     = 4'd4,
        EV_PROGRAM = 4'd5,
        EV_WHEEL   = 4'd6,
        EV_TEMPO   = 4'd7,
        EV_END     = 4'd8,
        EV_ERROR   = 4'd9
    } ev_kind_t;

    localparam logic [23:0] ERR_SIG    = 24'd1;
    localparam logic [23:0] ERR_FORMAT = 24'd2;
    localparam logic [23:0] ERR_DIV    = 24'd3;
    localparam logic [23:0] ERR_BIG    = 24'd4;

    typedef struct packed {
        ev_kind_t    kind;
        logic [3:0]  chan;
        logic [23:0] value;
        logic [31:0] ticks;
        logic [15:0] track;
    } ev_t;

endpackage
`default_nettype wire

// ===== src/mfsp_core.sv =====
`default_nettype none
module mfsp_core #(
    parameter int unsigned PROGRAM_COUNT = mfsp_pkg::PROGRAM_COUNT_DEF,
    parameter int unsigned MAX_TEMPOS    = mfsp_pkg::MAX_TEMPOS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   file_byte,
    input  wire logic [20:0]  max_events,
    output mfsp_pkg::ev_t     ev0,
    output mfsp_pkg::ev_t     ev1,
    output logic [1:0]        ev_n
);
    import mfsp_pkg::*;

    localparam int TW = $clog2(MAX_TEMPOS + 1);
    localparam logic [TW-1:0] TEMPO_LIM = TW'(MAX_TEMPOS);

    typedef enum logic [4:0] {
        PH_HSIG, PH_HLEN, PH_FMT, PH_NTRK, PH_DIV, PH_TSIG, PH_TLEN, PH_DELTA,
        PH_STATUS, PH_METATYPE, PH_EOTLEN, PH_TEMPO, PH_SKIPLEN, PH_SKIP,
        PH_DATA1, PH_DATA2, PH_DONE
    } phase_t;

    // program number folded into the program count, as a constant table
    function automatic logic [23:0] prog_mod(input logic [7:0] a);
        logic [23:0] r;
        r = '0;
        for (int i = 0; i < 256; i++)
            if (a == 8'(i)) r = 24'(i % PROGRAM_COUNT);
        return r;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] ttot_reg, ttot_next, tdone_reg, tdone_next;
    logic [31:0] ticks_reg, ticks_next, acc_reg, acc_next, skip_reg, skip_next;
    logic [7:0]  rs_reg, rs_next, fd_reg, fd_next, bend_reg, bend_next;
    logic [13:0] rpn_reg, rpn_next;
    logic [19:0] evc_reg, evc_next;
    logic [TW-1:0] tempo_reg, tempo_next;

    // combinational scratch
    logic [31:0] sh;
    logic [2:0]  cnt1;
    logic [19:0] lim;
    logic [20:0] csum;
    logic [19:0] cnew;
    logic [31:0] accn;
    logic [15:0] wv, wmul;
    logic [3:0]  hi;
    ev_kind_t    pk0, pk1;
    logic [23:0] pv0, pv1;
    logic [1:0]  pn;
    logic        close;
    logic [1:0]  closecnt;

    always_comb
    begin
        sh   = {shift_reg[23:0], file_byte};
        cnt1 = cnt_reg + 3'd1;
        lim  = (max_events == 21'd0) ? 20'd0
             : ((max_events - 21'd1) > 21'(COUNT_SAT)) ? COUNT_SAT
             : 20'(max_events - 21'd1);
        accn = {acc_reg[24:0], 7'd0} + {25'd0, file_byte[6:0]};
        hi   = rs_reg[7:4];
        wv   = 16'({8'd0, fd_reg} | ({8'd0, file_byte} << 7)) >> 1;
        wmul = 16'((wv - 16'h1000) * bend_reg + 16'h2000);

        phase_next = phase_reg; cnt_next = cnt_reg; shift_next = shift_reg;
        ttot_next = ttot_reg; tdone_next = tdone_reg; ticks_next = ticks_reg;
        acc_next = acc_reg; skip_next = skip_reg; rs_next = rs_reg;
        fd_next = fd_reg; bend_next = bend_reg; rpn_next = rpn_reg;
        evc_next = evc_reg; tempo_next = tempo_reg;
        pk0 = EV_HEADER; pk1 = EV_HEADER; pv0 = '0; pv1 = '0; pn = 2'd0;
        close = 1'b0; closecnt = 2'd0;
        ev0 = '0; ev1 = '0; ev_n = 2'd0;
        csum = '0; cnew = '0;

        case (phase_reg)
            PH_HSIG, PH_TSIG:
            begin
                shift_next = sh; cnt_next = cnt1;
                if (cnt1 == 3'd4)
                begin
                    cnt_next = '0; shift_next = '0;
                    if (sh != ((phase_reg == PH_HSIG) ? HDR_SIG : TRK_SIG))
                    begin
                        ev0.kind = EV_ERROR; ev0.value = ERR_SIG; ev_n = 2'd1;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = (phase_reg == PH_HSIG) ? PH_HLEN : PH_TLEN;
                end
            end
            PH_HLEN, PH_TLEN:
            begin
                shift_next = sh; cnt_next = cnt1;
                if (cnt1 == 3'd4)
                begin
                    cnt_next = '0; shift_next = '0;
                    if (phase_reg == PH_HLEN)
                        phase_next = PH_FMT;
                    else
                    begin
                        ticks_next = '0; acc_next = '0; phase_next = PH_DELTA;
                    end
                end
            end
            PH_FMT, PH_NTRK, PH_DIV:
            begin
                shift_next = sh; cnt_next = cnt1;
                if (cnt1 == 3'd2)
                begin
                    cnt_next = '0; shift_next = '0;
                    if (phase_reg == PH_FMT)
                    begin
                        if (sh[15:0] > 16'd1)
                        begin
                            ev0.kind = EV_ERROR; ev0.value = ERR_FORMAT; ev_n = 2'd1;
                            phase_next = PH_DONE;
                        end
                        else
                            phase_next = PH_NTRK;
                    end
                    else if (phase_reg == PH_NTRK)
                    begin
                        ttot_next = sh[15:0]; phase_next = PH_DIV;
                    end
                    else if (sh[15])
                    begin
                        ev0.kind = EV_ERROR; ev0.value = ERR_DIV; ev_n = 2'd1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        ev0.kind = EV_HEADER; ev0.value = {9'd0, sh[14:0]}; ev_n = 2'd1;
                        if (ttot_reg == 16'd0)
                        begin
                            ev1.kind = EV_END; ev1.value = {4'd0, evc_reg}; ev_n = 2'd2;
                            phase_next = PH_DONE;
                        end
                        else
                            phase_next = PH_TSIG;
                    end
                end
            end
            PH_DELTA:
            begin
                acc_next = accn;
                if (!file_byte[7])
                begin
                    ticks_next = ticks_reg + accn; acc_next = '0; phase_next = PH_STATUS;
                end
            end
            PH_STATUS, PH_DATA1:
            begin
                if (phase_reg == PH_STATUS && file_byte == 8'hFF)
                    phase_next = PH_METATYPE;
                else if (phase_reg == PH_STATUS && file_byte >= 8'hF0)
                begin
                    acc_next = '0; phase_next = PH_SKIPLEN;
                end
                else if (phase_reg == PH_STATUS && file_byte[7])
                begin
                    rs_next = file_byte; phase_next = PH_DATA1;
                end
                else
                begin
                    fd_next = file_byte;
                    if (hi == 4'h8 || hi == 4'h9 || hi == 4'hA || hi == 4'hB || hi == 4'hE)
                        phase_next = PH_DATA2;
                    else if (hi == 4'hC)
                    begin
                        pk0 = EV_PROGRAM;
                        pv0 = prog_mod(file_byte);
                        pn = 2'd1; close = 1'b1; closecnt = 2'd1;
                    end
                    else
                        close = 1'b1;
                end
            end
            PH_DATA2:
            begin
                case (hi)
                    4'h8:
                        if (rs_reg[3:0] != 4'd9)
                        begin
                            pk0 = EV_VEL; pn = 2'd1;
                        end
                    4'h9:
                        if (rs_reg[3:0] != 4'd9)
                        begin
                            pk0 = EV_VEL; pv0 = {16'd0, file_byte}; pn = 2'd1;
                            if (file_byte != 8'd0)
                            begin
                                pk1 = EV_PITCH; pv1 = {16'd0, fd_reg}; pn = 2'd2;
                            end
                        end
                    4'hB:
                        if (fd_reg == 8'h06)
                        begin
                            if (rpn_reg == '0) bend_next = file_byte;
                        end
                        else if (fd_reg == 8'h07)
                        begin
                            pk0 = EV_VOLUME; pv0 = {16'd0, file_byte}; pn = 2'd1;
                        end
                        else if (fd_reg == 8'h0A)
                        begin
                            pk0 = EV_PAN; pv0 = {16'd0, file_byte}; pn = 2'd1;
                        end
                        else if (fd_reg == 8'h64)
                            rpn_next = {rpn_reg[13:7], file_byte[6:0]};
                        else if (fd_reg == 8'h65)
                            rpn_next = {file_byte[6:0], rpn_reg[6:0]};
                    4'hE:
                    begin
                        pk0 = EV_WHEEL; pv0 = {8'd0, wmul}; pn = 2'd1;
                    end
                    default: ;
                endcase
                close = 1'b1; closecnt = pn;
            end
            PH_METATYPE:
            begin
                if (file_byte == 8'h2F)
                    phase_next = PH_EOTLEN;
                else if (file_byte == 8'h51)
                begin
                    cnt_next = '0; shift_next = '0; phase_next = PH_TEMPO;
                end
                else
                begin
                    acc_next = '0; phase_next = PH_SKIPLEN;
                end
            end
            PH_EOTLEN:
            begin
                tdone_next = tdone_reg + 16'd1;
                if (tdone_next == ttot_reg)
                begin
                    ev0.kind = EV_END; ev0.value = {4'd0, evc_reg};
                    ev0.track = tdone_next; ev_n = 2'd1;
                    phase_next = PH_DONE;
                end
                else
                    phase_next = PH_TSIG;
            end
            PH_TEMPO:
            begin
                shift_next = sh; cnt_next = cnt1;
                if (cnt1 == 3'd4)
                begin
                    cnt_next = '0; shift_next = '0;
                    if (tempo_reg >= TEMPO_LIM)
                    begin
                        ev0.kind = EV_ERROR; ev0.value = ERR_BIG; ev_n = 2'd1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        tempo_next = tempo_reg + TW'(1);
                        pk0 = EV_TEMPO; pv0 = sh[23:0]; pn = 2'd1; close = 1'b1;
                    end
                end
            end
            PH_SKIPLEN:
            begin
                acc_next = accn;
                if (!file_byte[7])
                begin
                    skip_next = accn; acc_next = '0;
                    if (accn == '0) close = 1'b1;
                    else phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (skip_reg != '0) skip_next = skip_reg - 32'd1;
                if (skip_reg <= 32'd1) close = 1'b1;
            end
            default: ;
        endcase

        if (close)
        begin
            csum = {1'b0, evc_reg} + 21'(closecnt);
            cnew = csum[20] ? COUNT_SAT : csum[19:0];
            evc_next = cnew;
            phase_next = PH_DELTA;
            acc_next = '0;
            if (cnew >= lim)
            begin
                ev0 = '0; ev0.kind = EV_ERROR; ev0.value = ERR_BIG; ev_n = 2'd1;
                phase_next = PH_DONE;
            end
            else
            begin
                ev0.kind = pk0; ev0.value = pv0;
                ev0.chan = (pk0 == EV_TEMPO) ? 4'd0 : rs_reg[3:0];
                ev1.kind = pk1; ev1.value = pv1; ev1.chan = rs_reg[3:0];
                ev_n = pn;
            end
        end
        if (phase_reg != PH_EOTLEN) ev0.track = tdone_reg;
        ev1.track = tdone_reg;
        ev0.ticks = ticks_reg;
        ev1.ticks = ticks_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HSIG; cnt_reg <= '0; shift_reg <= '0;
            ttot_reg <= '0; tdone_reg <= '0; ticks_reg <= '0; acc_reg <= '0;
            skip_reg <= '0; rs_reg <= '0; fd_reg <= '0; rpn_reg <= '0;
            bend_reg <= 8'd2; evc_reg <= '0; tempo_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next; cnt_reg <= cnt_next; shift_reg <= shift_next;
            ttot_reg <= ttot_next; tdone_reg <= tdone_next; ticks_reg <= ticks_next;
            acc_reg <= acc_next; skip_reg <= skip_next; rs_reg <= rs_next;
            fd_reg <= fd_next; rpn_reg <= rpn_next; bend_reg <= bend_next;
            evc_reg <= evc_next; tempo_reg <= tempo_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/midi_file_stream_parser.sv =====
`default_nettype none
// channel  | dir | handshake                   | payload
// in       | in  | in_valid / in_ready         | file_byte
// out      | out | out_valid / out_ready       | event_kind channel event_value
//          |     |                             | tick_offset track_index last
// cfg      | in  | cfg_we                      | cfg_data (max_events)
//
// one file byte per cycle while the buffer drains; the parse state advances
// in the same edge the byte is taken, and its up to two events land in a
// two-slot result buffer; a byte is taken whenever the buffer will be empty
// after this cycle, so a byte with two events holds input off until both go
// rst_n resets all parse state asynchronously; max_events returns to 65536
module midi_file_stream_parser #(
    parameter int unsigned PROGRAM_COUNT = mfsp_pkg::PROGRAM_COUNT_DEF,
    parameter int unsigned MAX_TEMPOS    = mfsp_pkg::MAX_TEMPOS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  file_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       event_kind,
    output logic [3:0]       channel,
    output logic [23:0]      event_value,
    output logic [31:0]      tick_offset,
    output logic [15:0]      track_index,
    output logic             last,
    input  wire logic        cfg_we,
    input  wire logic [20:0] cfg_data
);
    import mfsp_pkg::*;

    logic [20:0] max_reg;
    ev_t         ev0, ev1;
    logic [1:0]  ev_n;
    logic        step;

    // two-slot buffer: slot0 is the head shown on the port
    ev_t         slot0_reg, slot1_reg;
    logic        last0_reg, last1_reg;
    logic [1:0]  fill_reg;
    logic        pop;
    logic [1:0]  left;

    assign pop      = out_valid && out_ready;
    assign left     = fill_reg - {1'b0, pop};
    // accept only when leftovers are gone, so slot ordering stays trivial
    assign in_ready = (left == 2'd0);
    assign step     = in_valid && in_ready;

    mfsp_core #(
        .PROGRAM_COUNT (PROGRAM_COUNT),
        .MAX_TEMPOS    (MAX_TEMPOS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .file_byte  (file_byte),
        .max_events (max_reg),
        .ev0        (ev0),
        .ev1        (ev1),
        .ev_n       (ev_n)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= MAX_EVENTS_RST;
        else if (cfg_we)
            max_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (step)
            fill_reg <= ev_n;
        else
            fill_reg <= left;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            slot0_reg <= ev0;
            slot1_reg <= ev1;
            last0_reg <= (ev_n == 2'd1);
            last1_reg <= 1'b1;
        end
        else if (pop)
        begin
            // shift the second event forward
            slot0_reg <= slot1_reg;
            last0_reg <= last1_reg;
        end
    end

    assign out_valid   = (fill_reg != 2'd0);
    assign event_kind  = slot0_reg.kind;
    assign channel     = slot0_reg.chan;
    assign event_value = slot0_reg.value;
    assign tick_offset = slot0_reg.ticks;
    assign track_index = slot0_reg.track;
    assign last        = last0_reg;

endmodule
`default_nettype wire
